[rtl/tasc_pkg.sv]
// types and constants shared by the tone alarm sweep controller
`default_nettype none

package tasc_pkg;

  typedef enum logic [2:0] {
    OP_SET_BEEP  = 3'd0,
    OP_GET_BEEP  = 3'd1,
    OP_UPDATE    = 3'd2,
    OP_SET_ALARM = 3'd3,
    OP_GET_ALARM = 3'd4,
    OP_TICK      = 3'd5
  } opcode_t;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_BEEP  = 2'd1;
  localparam logic [1:0] EV_ALARM = 2'd2;

  localparam logic [7:0]  VOLUME_RESET = 8'd5;
  localparam logic [31:0] REMAIN_MAX   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [15:0] beep_freq;
    logic [7:0]  volume;
    logic [31:0] length;
    logic [15:0] low_bound;
    logic [15:0] high_bound;
    logic [15:0] step;
    logic [15:0] delay;
    logic [15:0] sweep_freq;
    logic        sweeping_up;
    logic        event_pending;
    logic [1:0]  pending_kind;
    logic [48:0] deadline;
    logic [48:0] next_step;
  } state_t;

  localparam state_t STATE_RESET = '{
    beep_freq:     16'd0,
    volume:        VOLUME_RESET,
    length:        32'd0,
    low_bound:     16'd0,
    high_bound:    16'd0,
    step:          16'd0,
    delay:         16'd0,
    sweep_freq:    16'd0,
    sweeping_up:   1'b1,
    event_pending: 1'b0,
    pending_kind:  EV_NONE,
    deadline:      49'd0,
    next_step:     49'd0
  };

  typedef struct packed {
    logic [2:0]  opcode;
    logic [47:0] time_ms;
    logic [15:0] beep_frequency;
    logic [7:0]  volume_level;
    logic [31:0] length_ms;
    logic [15:0] first_bound_hz;
    logic [15:0] second_bound_hz;
    logic [15:0] sweep_step_hz;
    logic [15:0] sweep_delay_ms;
  } item_t;

  typedef struct packed {
    logic [15:0] read_frequency;
    logic [7:0]  read_volume;
    logic [31:0] read_length;
    logic [15:0] read_low_bound;
    logic [15:0] read_high_bound;
    logic [15:0] read_step;
    logic [15:0] read_delay;
    logic [15:0] read_sweep_frequency;
    logic [31:0] remaining_ms;
    logic [1:0]  finished_event;
  } result_t;

endpackage

`default_nettype wire

[rtl/tasc_exec.sv]
// command evaluation: next controller state and result for one item
`default_nettype none

module tasc_exec import tasc_pkg::*; (
  input  state_t  state,
  input  item_t   item,
  output state_t  state_next,
  output result_t result
);

  logic [48:0] now;
  logic [48:0] deadline_new;
  logic [48:0] remain_diff;
  logic        bounds_ordered;

  assign now            = {1'b0, item.time_ms};
  assign deadline_new   = now + {17'd0, item.length_ms};
  assign remain_diff    = state.deadline - now;
  assign bounds_ordered = item.first_bound_hz <= item.second_bound_hz;

  always_comb begin
    state_next = state;
    result     = '0;
    unique case (item.opcode)
      OP_SET_BEEP: begin
        state_next.beep_freq     = item.beep_frequency;
        state_next.volume        = item.volume_level;
        state_next.length        = item.length_ms;
        state_next.pending_kind  = EV_BEEP;
        state_next.event_pending = 1'b1;
        state_next.deadline      = deadline_new;
      end
      OP_GET_BEEP: begin
        result.read_frequency = state.beep_freq;
        result.read_volume    = state.volume;
        result.read_length    = state.length;
      end
      OP_SET_ALARM: begin
        state_next.low_bound     = bounds_ordered ? item.first_bound_hz : item.second_bound_hz;
        state_next.high_bound    = bounds_ordered ? item.second_bound_hz : item.first_bound_hz;
        state_next.sweep_freq    = bounds_ordered ? item.first_bound_hz : item.second_bound_hz;
        state_next.step          = item.sweep_step_hz;
        state_next.delay         = item.sweep_delay_ms;
        state_next.length        = item.length_ms;
        state_next.sweeping_up   = 1'b1;
        state_next.pending_kind  = EV_ALARM;
        state_next.event_pending = 1'b1;
        state_next.deadline      = deadline_new;
        state_next.next_step     = now + {33'd0, item.sweep_delay_ms};
      end
      OP_GET_ALARM: begin
        result.read_volume          = state.volume;
        result.read_length          = state.length;
        result.read_low_bound       = state.low_bound;
        result.read_high_bound      = state.high_bound;
        result.read_step            = state.step;
        result.read_delay           = state.delay;
        result.read_sweep_frequency = state.sweep_freq;
        if (state.deadline != 49'd0 && now < state.deadline) begin
          // saturate when the gap does not fit 32 bits
          result.remaining_ms = (remain_diff[48:32] != 17'd0) ? REMAIN_MAX
                                                              : remain_diff[31:0];
        end
      end
      OP_TICK: begin
        if (state.event_pending) begin
          if (state.pending_kind == EV_ALARM && state.next_step <= now) begin
            // bounce between the bounds, reversing at the edge
            if (state.sweeping_up) begin
              if (state.sweep_freq < state.high_bound) begin
                state_next.sweep_freq = state.sweep_freq + state.step;
              end else begin
                state_next.sweeping_up = 1'b0;
                state_next.sweep_freq  = state.sweep_freq - state.step;
              end
            end else begin
              if (state.sweep_freq > state.low_bound) begin
                state_next.sweep_freq = state.sweep_freq - state.step;
              end else begin
                state_next.sweeping_up = 1'b1;
                state_next.sweep_freq  = state.sweep_freq + state.step;
              end
            end
            state_next.next_step = state.next_step + {33'd0, state.delay};
          end
          if (state.deadline <= now) begin
            result.finished_event    = state.pending_kind;
            state_next.event_pending = 1'b0;
          end
        end
      end
      default: begin
        // update command and unused codes leave everything alone
        state_next = state;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/tone_alarm_sweep_controller_unit.sv]
// Tone alarm sweep controller: one command item in, one result item out.
// Each item is registered on entry, evaluated against the controller state,
// and the result lands in an output register; a new item is accepted every
// cycle while in_stall is low, and out_valid rises when the item reaches the
// output register. The only thing that holds items back is out_stall: while
// the output register is full and stalled, an item waiting in the input register
// raises in_stall. State updates in item order as each item moves to the output.
`default_nettype none

module tone_alarm_sweep_controller_unit import tasc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  opcode,
  input  wire logic [47:0] time_ms,
  input  wire logic [15:0] beep_frequency,
  input  wire logic [7:0]  volume_level,
  input  wire logic [31:0] length_ms,
  input  wire logic [15:0] first_bound_hz,
  input  wire logic [15:0] second_bound_hz,
  input  wire logic [15:0] sweep_step_hz,
  input  wire logic [15:0] sweep_delay_ms,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      read_frequency,
  output logic [7:0]       read_volume,
  output logic [31:0]      read_length,
  output logic [15:0]      read_low_bound,
  output logic [15:0]      read_high_bound,
  output logic [15:0]      read_step,
  output logic [15:0]      read_delay,
  output logic [15:0]      read_sweep_frequency,
  output logic [31:0]      remaining_ms,
  output logic [1:0]       finished_event
);

  item_t   in_item;
  logic    in_full;
  state_t  state;
  state_t  state_next;
  result_t result_next;
  result_t result;
  logic    out_free;
  logic    advance;

  assign out_free = !out_valid || !out_stall;
  assign advance  = in_full && out_free;
  assign in_stall = in_full && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item <= '{
        opcode:          opcode,
        time_ms:         time_ms,
        beep_frequency:  beep_frequency,
        volume_level:    volume_level,
        length_ms:       length_ms,
        first_bound_hz:  first_bound_hz,
        second_bound_hz: second_bound_hz,
        sweep_step_hz:   sweep_step_hz,
        sweep_delay_ms:  sweep_delay_ms
      };
    end
  end

  tasc_exec u_exec (
    .state      (state),
    .item       (in_item),
    .state_next (state_next),
    .result     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign read_frequency       = result.read_frequency;
  assign read_volume          = result.read_volume;
  assign read_length          = result.read_length;
  assign read_low_bound       = result.read_low_bound;
  assign read_high_bound      = result.read_high_bound;
  assign read_step            = result.read_step;
  assign read_delay           = result.read_delay;
  assign read_sweep_frequency = result.read_sweep_frequency;
  assign remaining_ms         = result.remaining_ms;
  assign finished_event       = result.finished_event;

endmodule

`default_nettype wire

[rtl/tasc_checker.sv]
// port-level checks for the tone alarm sweep controller, bound to the top level
`default_nettype none

module tasc_checker import tasc_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [2:0]  opcode,
  input wire logic [47:0] time_ms,
  input wire logic [15:0] beep_frequency,
  input wire logic [7:0]  volume_level,
  input wire logic [31:0] length_ms,
  input wire logic [15:0] first_bound_hz,
  input wire logic [15:0] second_bound_hz,
  input wire logic [15:0] sweep_step_hz,
  input wire logic [15:0] sweep_delay_ms,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] read_frequency,
  input wire logic [7:0]  read_volume,
  input wire logic [31:0] read_length,
  input wire logic [15:0] read_low_bound,
  input wire logic [15:0] read_high_bound,
  input wire logic [15:0] read_step,
  input wire logic [15:0] read_delay,
  input wire logic [15:0] read_sweep_frequency,
  input wire logic [31:0] remaining_ms,
  input wire logic [1:0]  finished_event
);

  // output is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // input side only backs up when the output register is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without a stalled output item");

  // a finished event comes from a tick, which reads nothing back
  a_event_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished_event != EV_NONE |->
      finished_event != 2'd3 && read_volume == 8'd0 && read_length == 32'd0 &&
      remaining_ms == 32'd0 && read_frequency == 16'd0)
    else $error("finished event carries read-back data");

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_sweep_frequency) &&
      $stable(finished_event) && $stable(remaining_ms) && $stable(read_frequency) &&
      $stable(read_volume) && $stable(read_length) && $stable(read_low_bound) &&
      $stable(read_high_bound) && $stable(read_step) && $stable(read_delay))
    else $error("stalled output item changed");

  // a stalled input item is held by the sender
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(opcode) && $stable(time_ms) &&
      $stable(beep_frequency) && $stable(volume_level) && $stable(length_ms) &&
      $stable(first_bound_hz) && $stable(second_bound_hz) &&
      $stable(sweep_step_hz) && $stable(sweep_delay_ms))
    else $error("stalled input item changed");

endmodule

bind tone_alarm_sweep_controller_unit tasc_checker u_tasc_checker (.*);

`default_nettype wire

[sim/testbench.sv]
// testbench for the tone alarm sweep controller: directed command table, then random episodes
module testbench;
  import tasc_pkg::*;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int RANDOM_ITEMS = 1750;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam result_t NIL = '0;

  typedef struct packed {
    item_t   stim;
    logic    pinned;
    result_t want;
  } row_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_stall = 1'b1;
  item_t drive = '0;
  logic in_stall, out_valid;
  logic [15:0] read_frequency, read_low_bound, read_high_bound;
  logic [15:0] read_step, read_delay, read_sweep_frequency;
  logic [7:0]  read_volume;
  logic [31:0] read_length, remaining_ms;
  logic [1:0]  finished_event;

  state_t spk;
  result_t reply_q[$];
  result_t pin_want_q[$];
  logic pin_q[$];
  logic tx_quiet = 1'b0;
  int sent = 0;
  int results = 0;
  int errors = 0;
  int cycles = 0;
  int sweep_steps = 0;
  int reversals = 0;
  int beeps_done = 0;
  int alarms_done = 0;

  tone_alarm_sweep_controller_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(drive.opcode), .time_ms(drive.time_ms),
    .beep_frequency(drive.beep_frequency), .volume_level(drive.volume_level),
    .length_ms(drive.length_ms),
    .first_bound_hz(drive.first_bound_hz), .second_bound_hz(drive.second_bound_hz),
    .sweep_step_hz(drive.sweep_step_hz), .sweep_delay_ms(drive.sweep_delay_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_frequency(read_frequency), .read_volume(read_volume),
    .read_length(read_length), .read_low_bound(read_low_bound),
    .read_high_bound(read_high_bound), .read_step(read_step),
    .read_delay(read_delay), .read_sweep_frequency(read_sweep_frequency),
    .remaining_ms(remaining_ms), .finished_event(finished_event)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // next reply of the speaker controller, advancing its state
  function automatic result_t speaker_next(input item_t it);
    result_t r;
    logic [48:0] now, gap;
    r = '0;
    now = {1'b0, it.time_ms};
    case (it.opcode)
      OP_SET_BEEP: begin
        spk.beep_freq = it.beep_frequency;
        spk.volume = it.volume_level;
        spk.length = it.length_ms;
        spk.pending_kind = EV_BEEP;
        spk.event_pending = 1'b1;
        spk.deadline = now + {17'd0, it.length_ms};
      end
      OP_GET_BEEP: begin
        r.read_frequency = spk.beep_freq;
        r.read_volume = spk.volume;
        r.read_length = spk.length;
      end
      OP_SET_ALARM: begin
        if (it.first_bound_hz <= it.second_bound_hz) begin
          spk.low_bound = it.first_bound_hz;
          spk.high_bound = it.second_bound_hz;
        end else begin
          spk.low_bound = it.second_bound_hz;
          spk.high_bound = it.first_bound_hz;
        end
        spk.step = it.sweep_step_hz;
        spk.delay = it.sweep_delay_ms;
        spk.length = it.length_ms;
        spk.sweep_freq = spk.low_bound;
        spk.sweeping_up = 1'b1;
        spk.pending_kind = EV_ALARM;
        spk.event_pending = 1'b1;
        spk.deadline = now + {17'd0, it.length_ms};
        spk.next_step = now + {33'd0, it.sweep_delay_ms};
      end
      OP_GET_ALARM: begin
        if (spk.deadline != 0 && now < spk.deadline) begin
          gap = spk.deadline - now;
          r.remaining_ms = (gap[48:32] != 0) ? REMAIN_MAX : gap[31:0];
        end
        r.read_volume = spk.volume;
        r.read_length = spk.length;
        r.read_low_bound = spk.low_bound;
        r.read_high_bound = spk.high_bound;
        r.read_step = spk.step;
        r.read_delay = spk.delay;
        r.read_sweep_frequency = spk.sweep_freq;
      end
      OP_TICK: begin
        if (spk.event_pending) begin
          if (spk.pending_kind == EV_ALARM && spk.next_step <= now) begin
            sweep_steps++;
            // bounce off a bound: the step that reverses still moves the tone
            if (spk.sweeping_up) begin
              if (spk.sweep_freq < spk.high_bound) begin
                spk.sweep_freq = spk.sweep_freq + spk.step;
              end else begin
                spk.sweeping_up = 1'b0;
                spk.sweep_freq = spk.sweep_freq - spk.step;
                reversals++;
              end
            end else begin
              if (spk.sweep_freq > spk.low_bound) begin
                spk.sweep_freq = spk.sweep_freq - spk.step;
              end else begin
                spk.sweeping_up = 1'b1;
                spk.sweep_freq = spk.sweep_freq + spk.step;
                reversals++;
              end
            end
            spk.next_step = spk.next_step + {33'd0, spk.delay};
          end
          if (spk.deadline <= now) begin
            r.finished_event = spk.pending_kind;
            spk.event_pending = 1'b0;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic item_t cmd(input logic [2:0] op, input logic [47:0] t,
                                input logic [15:0] freq, input logic [7:0] vol,
                                input logic [31:0] len, input logic [15:0] b1,
                                input logic [15:0] b2, input logic [15:0] step,
                                input logic [15:0] delay);
    return {op, t, freq, vol, len, b1, b2, step, delay};
  endfunction

  function automatic result_t reply(input logic [15:0] freq, input logic [7:0] vol,
                                    input logic [31:0] len, input logic [15:0] lo,
                                    input logic [15:0] hi, input logic [15:0] step,
                                    input logic [15:0] delay, input logic [15:0] sweep,
                                    input logic [31:0] rem, input logic [1:0] ev);
    return {freq, vol, len, lo, hi, step, delay, sweep, rem, ev};
  endfunction

  function automatic item_t random_item();
    item_t it;
    logic [63:0] wide;
    wide = {$urandom(), $urandom()};
    it.opcode = 3'($urandom_range(0, 7));
    it.time_ms = wide[47:0];
    it.beep_frequency = 16'($urandom());
    it.volume_level = 8'($urandom());
    it.length_ms = $urandom();
    it.first_bound_hz = 16'($urandom());
    it.second_bound_hz = 16'($urandom());
    it.sweep_step_hz = 16'($urandom());
    it.sweep_delay_ms = 16'($urandom());
    return it;
  endfunction

  task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] got);
    $error("%s: expected %0h, got %0h", name, want, got);
    errors++;
  endtask

  task automatic check_result(input result_t want, input result_t got);
    if (got.read_frequency !== want.read_frequency)
      flag_field("read_frequency", 32'(want.read_frequency), 32'(got.read_frequency));
    if (got.read_volume !== want.read_volume)
      flag_field("read_volume", 32'(want.read_volume), 32'(got.read_volume));
    if (got.read_length !== want.read_length)
      flag_field("read_length", want.read_length, got.read_length);
    if (got.read_low_bound !== want.read_low_bound)
      flag_field("read_low_bound", 32'(want.read_low_bound), 32'(got.read_low_bound));
    if (got.read_high_bound !== want.read_high_bound)
      flag_field("read_high_bound", 32'(want.read_high_bound), 32'(got.read_high_bound));
    if (got.read_step !== want.read_step)
      flag_field("read_step", 32'(want.read_step), 32'(got.read_step));
    if (got.read_delay !== want.read_delay)
      flag_field("read_delay", 32'(want.read_delay), 32'(got.read_delay));
    if (got.read_sweep_frequency !== want.read_sweep_frequency)
      flag_field("read_sweep_frequency", 32'(want.read_sweep_frequency),
                 32'(got.read_sweep_frequency));
    if (got.remaining_ms !== want.remaining_ms)
      flag_field("remaining_ms", want.remaining_ms, got.remaining_ms);
    if (got.finished_event !== want.finished_event)
      flag_field("finished_event", 32'(want.finished_event), 32'(got.finished_event));
  endtask

  task automatic send_item(input item_t it, input logic pin, input result_t want);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    drive <= it;
    in_valid <= 1'b1;
    pin_q.insert(pin_q.size(), pin);
    pin_want_q.insert(pin_want_q.size(), want);
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // output side checked before input side: no reply can leave in the cycle its item enters
  always @(posedge clk) begin : scoreboard
    result_t got, want, pred;
    logic pin;
    if (rst) begin
      spk = '0;
      spk.volume = 8'd5;
      spk.sweeping_up = 1'b1;
    end else begin
      if (out_valid && !out_stall) begin
        got = {read_frequency, read_volume, read_length, read_low_bound, read_high_bound,
               read_step, read_delay, read_sweep_frequency, remaining_ms, finished_event};
        if (reply_q.size() == 0) begin
          $error("result item arrived with no reply waiting");
          errors++;
        end else begin
          want = reply_q.pop_front();
          check_result(want, got);
        end
        results++;
      end
      if (in_valid && !in_stall) begin
        pred = speaker_next(drive);
        pin = pin_q.pop_front();
        want = pin_want_q.pop_front();
        reply_q.insert(reply_q.size(), pin ? want : pred);
        if (pred.finished_event == EV_BEEP) beeps_done++;
        if (pred.finished_event == EV_ALARM) alarms_done++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // receiver: random stalls, quiet stretches, and two long hold-offs to back up the input
  initial begin
    int wait_cycles, taken;
    logic quiet;
    quiet = 1'b0;
    taken = 0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (taken % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (taken == 40 || taken == 1000) wait_cycles = HOLD_CYCLES;
      else wait_cycles = quiet ? 0 : $urandom_range(0, 18);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin
    row_t rows[$];
    item_t it;
    logic [47:0] now_ms;
    int n, pick, noise;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset values read back, tick with nothing armed
    rows.insert(rows.size(), '{cmd(OP_GET_BEEP, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                               reply(0, 5, 0, 0, 0, 0, 0, 0, 0, EV_NONE)});
    rows.insert(rows.size(), '{cmd(OP_GET_ALARM, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                               reply(0, 5, 0, 0, 0, 0, 0, 0, 0, EV_NONE)});
    rows.insert(rows.size(), '{cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, NIL});
    // update and spare opcodes with every field at its top
    rows.insert(rows.size(), '{cmd(OP_UPDATE, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 8'hFF,
                                   32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                   16'hFFFF), 1'b1, NIL});
    rows.insert(rows.size(), '{cmd(OP_SPARE_6, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 8'hFF,
                                   32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                   16'hFFFF), 1'b1, NIL});
    rows.insert(rows.size(), '{cmd(OP_SPARE_7, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 8'hFF,
                                   32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                   16'hFFFF), 1'b1, NIL});
    // longest beep, read back both ways
    rows.insert(rows.size(), '{cmd(OP_SET_BEEP, 100, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF,
                                   0, 0, 0, 0), 1'b1, NIL});
    rows.insert(rows.size(), '{cmd(OP_GET_BEEP, 100, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                               reply(16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0,
                                     EV_NONE)});
    rows.insert(rows.size(), '{cmd(OP_GET_ALARM, 100, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                               reply(0, 8'hFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0,
                                     32'hFFFF_FFFF, EV_NONE)});
    rows.insert(rows.size(), '{cmd(OP_TICK, 101, 0, 0, 0, 0, 0, 0, 0), 1'b1, NIL});
    // zero-length beep finishes on the first tick, and only once
    rows.insert(rows.size(), '{cmd(OP_SET_BEEP, 200, 1000, 0, 0, 0, 0, 0, 0), 1'b1, NIL});
    rows.insert(rows.size(), '{cmd(OP_TICK, 200, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                               reply(0, 0, 0, 0, 0, 0, 0, 0, 0, EV_BEEP)});
    rows.insert(rows.size(), '{cmd(OP_TICK, 200, 0, 0, 0, 0, 0, 0, 0), 1'b1, NIL});
    // bounds given high first, volume on set alarm ignored
    rows.insert(rows.size(), '{cmd(OP_SET_ALARM, 1000, 0, 8'hAA, 100, 3000, 1000, 500, 10),
                               1'b1, NIL});
    rows.insert(rows.size(), '{cmd(OP_GET_ALARM, 1000, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                               reply(0, 0, 100, 1000, 3000, 500, 10, 1000, 100, EV_NONE)});
    rows.insert(rows.size(), '{cmd(OP_TICK, 1010, 0, 0, 0, 0, 0, 0, 0), 1'b0, NIL});
    rows.insert(rows.size(), '{cmd(OP_TICK, 1050, 0, 0, 0, 0, 0, 0, 0), 1'b0, NIL});
    rows.insert(rows.size(), '{cmd(OP_TICK, 1100, 0, 0, 0, 0, 0, 0, 0), 1'b0, NIL});
    // alarm at the end of time, then time goes back: remaining saturates
    rows.insert(rows.size(), '{cmd(OP_SET_ALARM, 48'hFFFF_FFFF_FFFF, 0, 0, 32'hFFFF_FFFF,
                                   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1, NIL});
    rows.insert(rows.size(), '{cmd(OP_GET_ALARM, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                               reply(0, 0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                     16'hFFFF, 16'hFFFF, REMAIN_MAX, EV_NONE)});
    rows.insert(rows.size(), '{cmd(OP_TICK, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0, 0),
                               1'b0, NIL});
    // flat sweep at zero wraps below zero
    rows.insert(rows.size(), '{cmd(OP_SET_ALARM, 0, 0, 0, 5, 0, 0, 1, 0), 1'b0, NIL});
    rows.insert(rows.size(), '{cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, NIL});
    rows.insert(rows.size(), '{cmd(OP_TICK, 1, 0, 0, 0, 0, 0, 0, 0), 1'b0, NIL});
    rows.insert(rows.size(), '{cmd(OP_GET_ALARM, 2, 0, 0, 0, 0, 0, 0, 0), 1'b0, NIL});
    rows.insert(rows.size(), '{cmd(OP_TICK, 5, 0, 0, 0, 0, 0, 0, 0), 1'b0, NIL});

    foreach (rows[i]) send_item(rows[i].stim, rows[i].pinned, rows[i].want);

    // random episodes: arm a beep or alarm, then let time run with ticks and reads
    now_ms = 48'd2000;
    while (sent < RANDOM_ITEMS + rows.size()) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        it = random_item();
        now_ms = it.time_ms;
      end else if (pick == 1) begin
        now_ms = now_ms - 48'($urandom_range(0, 500));
      end
      if ($urandom_range(0, 9) < 8) begin
        it = random_item();
        it.time_ms = now_ms;
        it.length_ms = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 300);
        if ($urandom_range(0, 4) < 3) begin
          it.opcode = OP_SET_ALARM;
          if ($urandom_range(0, 3) != 0) begin
            it.first_bound_hz = 16'($urandom_range(0, 4000));
            it.second_bound_hz = 16'($urandom_range(0, 4000));
          end
          if ($urandom_range(0, 3) != 0) it.sweep_step_hz = 16'($urandom_range(0, 400));
          if ($urandom_range(0, 7) != 0) it.sweep_delay_ms = 16'($urandom_range(0, 16));
        end else begin
          it.opcode = OP_SET_BEEP;
        end
        send_item(it, 1'b0, NIL);
        n = $urandom_range(4, 40);
        repeat (n) begin
          now_ms = now_ms + 48'($urandom_range(0, 12));
          it = random_item();
          it.time_ms = now_ms;
          pick = $urandom_range(0, 39);
          if (pick < 28) it.opcode = OP_TICK;
          else if (pick < 34) it.opcode = OP_GET_ALARM;
          else if (pick < 37) it.opcode = OP_GET_BEEP;
          else if (pick < 39) it.opcode = OP_UPDATE;
          else begin
            it.opcode = OP_SET_BEEP;
            it.length_ms = $urandom_range(0, 100);
          end
          send_item(it, 1'b0, NIL);
        end
      end else begin
        // noise: any opcode, any field, time often far off
        noise = $urandom_range(1, 4);
        repeat (noise) begin
          it = random_item();
          if ($urandom_range(0, 1) == 0) it.time_ms = now_ms;
          send_item(it, 1'b0, NIL);
        end
      end
    end
    in_valid <= 1'b0;

    while (results < sent) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d command items and %0d replies in %0d cycles", sent, results, cycles);
    $display("sweep: %0d steps, %0d bounces; finished: %0d beeps, %0d alarms; %0d mismatches",
             sweep_steps, reversals, beeps_done, alarms_done, errors);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/tasc_pkg.sv
rtl/tasc_exec.sv
rtl/tone_alarm_sweep_controller_unit.sv
rtl/tasc_checker.sv
sim/testbench.sv
